// ----- hw/rtl/rrt_pkg.sv -----
package rrt_pkg;

	// default sizing of the rename tables
	localparam int NUM_TYPES_DEF = 4;
	localparam int ARCH_REGS_DEF = 32;
	localparam int PHYS_REGS_DEF = 128;

	// stream payload widths, bytes-rounded
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 24;

	typedef enum logic [2:0] {
		CMD_LOOKUP    = 3'd0,
		CMD_CAN_ALLOC = 3'd1,
		CMD_ALLOCATE  = 3'd2,
		CMD_COMMIT    = 3'd3,
		CMD_REWIND    = 3'd4,
		CMD_FREE      = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_HOLD
	} state_t;

	// result transaction, mapped_tag in the lowest bits
	typedef struct packed {
		logic [7:0] free_count;
		status_t    status;
		logic       allowed;
		logic [6:0] mapped_tag;
	} res_t;

endpackage

// ----- hw/rtl/register_rename_table_core.sv -----
// Register renamer with one alias table, free list, history store and destination store per
// register type, all held in synchronous memories. In a command transaction the accepting edge
// reads the stores, the cycle after it modifies and writes them back and hands the result to
// the output register; the block takes no new command until it is done with the last one. A
// result that cannot enter the output register holds the block for as long as the output is
// stalled. After reset a fill sweep loads the alias tables with the identity mapping and the
// free lists with their initial tags; s_tready stays low during the sweep.
module register_rename_table_core
	import rrt_pkg::*;
#(
	parameter int NUM_TYPES = NUM_TYPES_DEF,
	parameter int ARCH_REGS = ARCH_REGS_DEF,
	parameter int PHYS_REGS = PHYS_REGS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// cmd[2:0], reg_type[4:3], reg_tag[11:5], quantity[19:12], zero fill above
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// mapped_tag[6:0], allowed[7], status[9:8], free_count[17:10], zero fill above
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int AW = (ARCH_REGS > 1) ? $clog2(ARCH_REGS) : 1;
	localparam int PW = $clog2(PHYS_REGS);
	localparam int CW = $clog2(PHYS_REGS + 1);
	localparam int INIT_FREE = (PHYS_REGS > ARCH_REGS) ? PHYS_REGS - ARCH_REGS : 0;

	function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
		next_slot = (p == PW'(PHYS_REGS - 1)) ? '0 : p + PW'(1);
	endfunction

	// stores
	logic [PW-1:0] map_mem  [NUM_TYPES][ARCH_REGS];
	logic [PW-1:0] hist_mem [NUM_TYPES][PHYS_REGS];
	logic [AW-1:0] dest_mem [NUM_TYPES][PHYS_REGS];
	logic [PW-1:0] fifo_mem [NUM_TYPES][PHYS_REGS];

	// free list pointers per type
	logic [PW-1:0] head_q  [NUM_TYPES];
	logic [PW-1:0] tail_q  [NUM_TYPES];
	logic [CW-1:0] count_q [NUM_TYPES];

	state_t state_q, state_d;
	logic [TW-1:0] init_t_q;
	logic [PW-1:0] init_s_q;
	logic          init_last;

	// command fields captured at acceptance
	cmd_t          cmd_s1;
	logic [TW-1:0] tidx_s1;
	logic          type_ok_s1, arch_ok_s1, phys_ok_s1;
	logic [AW-1:0] aidx_s1;
	logic [PW-1:0] pidx_s1;
	logic [7:0]    qty_s1;

	// read data
	logic [PW-1:0] map_rd_s1, hist_rd_s1, fifo_rd_s1;
	logic [AW-1:0] dest_rd_s1;

	// input decode
	logic [2:0]    in_cmd;
	logic [1:0]    in_type;
	logic [6:0]    in_tag;
	logic          in_type_ok, in_acc;
	logic [TW-1:0] in_tsel;
	logic [AW-1:0] in_aidx;
	logic [PW-1:0] in_pidx;

	// control
	logic out_free, load_res, load_pend, exec_en;

	// execute stage
	logic [CW-1:0] cnt_cur, cnt_new;
	logic [PW-1:0] head_cur, tail_cur;
	logic [PW-1:0] ex_mapped;
	logic          ex_allowed, ex_pop, ex_push_req, ex_push;
	logic [PW-1:0] ex_push_tag;
	status_t       ex_status;
	logic          ex_map_we, ex_hd_we;
	logic [AW-1:0] ex_map_wa;
	logic [PW-1:0] ex_map_wd;
	res_t          res_d, res_q, pend_q;
	logic          m_tvalid_q;

	// memory write ports
	logic          map_we, fifo_we;
	logic [TW-1:0] map_wt, fifo_wt;
	logic [AW-1:0] map_wa;
	logic [PW-1:0] map_wd, fifo_wa, fifo_wd;

	assign in_cmd     = s_tdata[2:0];
	assign in_type    = s_tdata[4:3];
	assign in_tag     = s_tdata[11:5];
	assign in_type_ok = 32'(in_type) < NUM_TYPES;
	assign in_tsel    = in_type_ok ? TW'(in_type) : '0;
	assign in_aidx    = AW'(in_tag);
	assign in_pidx    = PW'(in_tag);
	assign in_acc     = s_tvalid && s_tready;
	assign init_last  = (init_t_q == TW'(NUM_TYPES - 1)) && (init_s_q == PW'(PHYS_REGS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: if (init_last) state_d = S_IDLE;
			S_IDLE: if (s_tvalid) state_d = S_EXEC;
			S_EXEC: state_d = out_free ? S_IDLE : S_HOLD;
			S_HOLD: if (m_tready) state_d = S_IDLE;
			default: state_d = S_INIT;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready  = (state_q == S_IDLE);
		exec_en   = (state_q == S_EXEC);
		out_free  = !m_tvalid_q || m_tready;
		load_res  = exec_en && out_free;
		load_pend = (state_q == S_HOLD) && m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			init_t_q <= '0;
			init_s_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) begin
				if (init_s_q == PW'(PHYS_REGS - 1)) begin
					init_s_q <= '0;
					init_t_q <= init_t_q + TW'(1);
				end else begin
					init_s_q <= init_s_q + PW'(1);
				end
			end
		end
	end

	// capture command fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1     <= cmd_t'(in_cmd);
			tidx_s1    <= in_tsel;
			type_ok_s1 <= in_type_ok;
			arch_ok_s1 <= 32'(in_tag) < ARCH_REGS;
			phys_ok_s1 <= 32'(in_tag) < PHYS_REGS;
			aidx_s1    <= in_aidx;
			pidx_s1    <= in_pidx;
			qty_s1     <= s_tdata[19:12];
		end
	end

	// execute: read-modify-write of the stores
	assign cnt_cur  = count_q[tidx_s1];
	assign head_cur = head_q[tidx_s1];
	assign tail_cur = tail_q[tidx_s1];

	always_comb begin
		ex_mapped   = '0;
		ex_allowed  = 1'b0;
		ex_status   = ST_OK;
		ex_pop      = 1'b0;
		ex_push_req = 1'b0;
		ex_push_tag = pidx_s1;
		ex_map_we   = 1'b0;
		ex_map_wa   = aidx_s1;
		ex_map_wd   = fifo_rd_s1;
		ex_hd_we    = 1'b0;
		if (type_ok_s1) begin
			case (cmd_s1)
				CMD_LOOKUP: begin
					if (arch_ok_s1) ex_mapped = map_rd_s1;
				end
				CMD_CAN_ALLOC: begin
					ex_allowed = 32'(cnt_cur) >= 32'(qty_s1);
				end
				CMD_ALLOCATE: begin
					if (arch_ok_s1) begin
						if (cnt_cur == '0) begin
							ex_status = ST_EMPTY;
						end else begin
							ex_pop    = 1'b1;
							ex_mapped = fifo_rd_s1;
							ex_map_we = 1'b1;
							ex_hd_we  = 32'(fifo_rd_s1) < PHYS_REGS;
						end
					end
				end
				CMD_COMMIT: begin
					ex_push_req = phys_ok_s1;
					ex_push_tag = hist_rd_s1;
				end
				CMD_REWIND: begin
					if (phys_ok_s1) begin
						ex_push_req = 1'b1;
						ex_map_we   = 32'(dest_rd_s1) < ARCH_REGS;
						ex_map_wa   = dest_rd_s1;
						ex_map_wd   = hist_rd_s1;
					end
				end
				CMD_FREE: begin
					ex_push_req = phys_ok_s1;
				end
				default: begin
				end
			endcase
		end
		// push onto the free list, dropped when full
		ex_push = 1'b0;
		if (ex_push_req) begin
			if (cnt_cur == CW'(PHYS_REGS)) ex_status = ST_OVERFLOW;
			else ex_push = 1'b1;
		end
		cnt_new = cnt_cur - CW'(ex_pop) + CW'(ex_push);
		res_d.mapped_tag = 7'(ex_mapped);
		res_d.allowed    = ex_allowed;
		res_d.status     = ex_status;
		res_d.free_count = type_ok_s1 ? 8'(cnt_new) : 8'd0;
	end

	// write port selection: fill sweep or execute stage
	always_comb begin
		if (state_q == S_INIT) begin
			map_we  = 32'(init_s_q) < ARCH_REGS;
			map_wt  = init_t_q;
			map_wa  = AW'(init_s_q);
			map_wd  = init_s_q;
			fifo_we = 1'b1;
			fifo_wt = init_t_q;
			fifo_wa = init_s_q;
			fifo_wd = PW'(32'(init_s_q) + ARCH_REGS);
		end else begin
			map_we  = exec_en && ex_map_we;
			map_wt  = tidx_s1;
			map_wa  = ex_map_wa;
			map_wd  = ex_map_wd;
			fifo_we = exec_en && ex_push;
			fifo_wt = tidx_s1;
			fifo_wa = tail_cur;
			fifo_wd = ex_push_tag;
		end
	end

	// alias table
	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_wt][map_wa] <= map_wd;
		if (in_acc) map_rd_s1 <= map_mem[in_tsel][in_aidx];
	end

	// free list storage
	always_ff @(posedge clk) begin
		if (fifo_we) fifo_mem[fifo_wt][fifo_wa] <= fifo_wd;
		if (in_acc) fifo_rd_s1 <= fifo_mem[in_tsel][head_q[in_tsel]];
	end

	// history and destination stores, written together on allocate
	always_ff @(posedge clk) begin
		if (exec_en && ex_hd_we) begin
			hist_mem[tidx_s1][fifo_rd_s1] <= map_rd_s1;
			dest_mem[tidx_s1][fifo_rd_s1] <= aidx_s1;
		end
		if (in_acc) begin
			hist_rd_s1 <= hist_mem[in_tsel][in_pidx];
			dest_rd_s1 <= dest_mem[in_tsel][in_pidx];
		end
	end

	// free list pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TYPES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= PW'(INIT_FREE % PHYS_REGS);
				count_q[i] <= CW'(INIT_FREE);
			end
		end else if (exec_en) begin
			if (ex_pop) head_q[tidx_s1] <= next_slot(head_cur);
			if (ex_push) tail_q[tidx_s1] <= next_slot(tail_cur);
			count_q[tidx_s1] <= cnt_new;
		end
	end

	// output register with a pending slot behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_res || load_pend) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) res_q <= res_d;
		else if (load_pend) res_q <= pend_q;
		if (exec_en && !out_free) pend_q <= res_d;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_DATA_W - $bits(res_t))'(0), res_q};

	// checks

	// a held result keeps the output register occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD) |-> m_tvalid_q)
		else $error("pending result without a valid output");

	// a successful pop lowers the free count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(exec_en && ex_pop) |=> (count_q[tidx_s1] == $past(cnt_cur) - CW'(1)))
		else $error("free count not decremented on allocate");

	// an empty-list allocate reports no free tags
	assert property (@(posedge clk) disable iff (!arst_n)
		(load_res && res_d.status == ST_EMPTY) |-> (res_d.free_count == 8'd0))
		else $error("empty status with nonzero free count");

	for (genvar gi = 0; gi < NUM_TYPES; gi++) begin : g_chk
		// count agrees with the pointer distance and never exceeds the list size
		assert property (@(posedge clk) disable iff (!arst_n)
			(32'(count_q[gi]) <= PHYS_REGS) &&
			((32'(count_q[gi]) == 32'(tail_q[gi]) - 32'(head_q[gi]) +
				((tail_q[gi] < head_q[gi]) ? PHYS_REGS : 0)) ||
			 (32'(count_q[gi]) == PHYS_REGS && tail_q[gi] == head_q[gi])))
			else $error("free list pointers and count disagree");
	end

endmodule
